// ===== hw/rtl/console_line_editor_macros.svh =====
// Assertion macros for the console line editor checker.
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// Checked on every edge outside reset.
`define CLE_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) else $error(msg);

// Checked on every edge, reset included.
`define CLE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) expr) else $error(msg);

`endif

// ===== hw/rtl/cle_pkg.sv =====
// Shared constants and types for the console line editor.
package cle_pkg;

    localparam int LINE_SIZE = 64;
    localparam int IDX_W     = $clog2(LINE_SIZE);

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // Kind of echo sequence an accepted byte produces.
    typedef enum logic [1:0] {
        OP_CHR = 2'd0,
        OP_CR  = 2'd1,
        OP_DEL = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  ch;
        logic        complete;
        logic [5:0]  length;
        logic [15:0] count;
    } t_entry;

endpackage

// ===== hw/rtl/cle_editor.sv =====
// Line editor state: write index, line count, and the decoded echo entry register.
module cle_editor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rx_valid,
    output logic            o_rx_ready,
    input  logic [7:0]      i_rx_byte,
    output logic            o_ent_valid,
    input  logic            i_ent_ready,
    output cle_pkg::t_entry o_ent
);

    logic [cle_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [15:0]               r_count, n_count;
    logic                      r_ent_valid, n_ent_valid;
    cle_pkg::t_entry           r_ent, n_ent;

    logic accept;
    logic is_cr, is_del, is_chr, emits;
    logic line_open;

    assign o_rx_ready = !r_ent_valid || i_ent_ready;
    assign accept     = i_rx_valid && o_rx_ready;

    assign line_open = (r_idx != '0);
    assign is_cr     = (i_rx_byte == cle_pkg::CH_CR);
    assign is_del    = (i_rx_byte == cle_pkg::CH_DEL) && line_open;
    assign is_chr    = (i_rx_byte >= cle_pkg::CH_SPACE) && (i_rx_byte <= cle_pkg::CH_TILDE)
                       && (r_idx < cle_pkg::IDX_W'(cle_pkg::LINE_SIZE - 1));
    assign emits     = is_cr || is_del || is_chr;

    always_comb begin
        n_idx   = r_idx;
        n_count = r_count;
        n_ent   = r_ent;
        if (accept) begin
            priority if (is_cr) begin
                n_idx = '0;
                if (line_open) n_count = r_count + 16'd1;
                n_ent.op = cle_pkg::OP_CR;
            end else if (is_del) begin
                n_idx    = r_idx - cle_pkg::IDX_W'(1);
                n_ent.op = cle_pkg::OP_DEL;
            end else if (is_chr) begin
                n_idx    = r_idx + cle_pkg::IDX_W'(1);
                n_ent.op = cle_pkg::OP_CHR;
            end else begin
                // ignored byte: index and entry hold
                n_idx = r_idx;
            end
            if (emits) begin
                n_ent.ch       = i_rx_byte;
                n_ent.complete = is_cr && line_open;
                n_ent.length   = 6'(n_idx);
                n_ent.count    = n_count;
            end
        end
    end

    assign n_ent_valid = (r_ent_valid && !i_ent_ready) || (accept && emits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_ent_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_ent_valid <= n_ent_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent_valid = r_ent_valid;
    assign o_ent       = r_ent;

endmodule

// ===== hw/rtl/cle_echo.sv =====
// Echo sequencer: result register that plays out one to three bytes per entry.
module cle_echo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ent_valid,
    output logic            o_ent_ready,
    input  cle_pkg::t_entry i_ent,
    output logic            o_tx_valid,
    input  logic            i_tx_ready,
    output logic [7:0]      o_tx_byte,
    output logic            o_last,
    output logic            o_line_complete,
    output logic [5:0]      o_line_length,
    output logic [15:0]     o_message_count
);

    logic            r_busy, n_busy;
    logic [1:0]      r_pos, n_pos;
    cle_pkg::t_entry r_ent, n_ent;

    logic       last;
    logic [7:0] tx_byte;
    logic       load;

    always_comb begin
        unique case (r_ent.op)
            cle_pkg::OP_CHR: begin
                tx_byte = r_ent.ch;
                last    = 1'b1;
            end
            cle_pkg::OP_CR: begin
                tx_byte = (r_pos == 2'd0) ? cle_pkg::CH_CR : cle_pkg::CH_LF;
                last    = (r_pos == 2'd1);
            end
            cle_pkg::OP_DEL: begin
                tx_byte = (r_pos == 2'd1) ? cle_pkg::CH_SPACE : cle_pkg::CH_DEL;
                last    = (r_pos == 2'd2);
            end
            default: begin
                tx_byte = r_ent.ch;
                last    = 1'b1;
            end
        endcase
    end

    assign o_ent_ready = !r_busy || (i_tx_ready && last);
    assign load        = i_ent_valid && o_ent_ready;

    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        n_ent  = r_ent;
        if (load) begin
            n_busy = 1'b1;
            n_pos  = 2'd0;
            n_ent  = i_ent;
        end else if (r_busy && i_tx_ready) begin
            n_busy = !last;
            n_pos  = r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_tx_valid      = r_busy;
    assign o_tx_byte       = tx_byte;
    assign o_last          = last;
    assign o_line_complete = r_ent.complete;
    assign o_line_length   = r_ent.length;
    assign o_message_count = r_ent.count;

endmodule

// ===== hw/rtl/console_line_editor.sv =====
// Top level of the console line editor with echo.
//
//  channel | direction | handshake              | payload
//  rx      | in        | i_rx_valid / o_rx_ready | i_rx_byte
//  tx      | out       | o_tx_valid / i_tx_ready | o_tx_byte, o_last, o_line_complete,
//          |           |                         | o_line_length, o_message_count
//
// An rx byte is decoded in the cycle it transfers and lands in the entry
// register; the echo register picks it up from there once it is free, and
// plays out its echo bytes. The tx side moves one byte per cycle while
// i_tx_ready is high, and an item echoes 1 (printable), 2 (carriage return)
// or 3 (DEL) bytes. Bytes that echo nothing never reach the tx side.
// Reset clears the write index, the line count and both entry valids.
// A tx stall backs up through the echo register into the entry register and
// then drops o_rx_ready; one decoded entry waits while the echo is busy.
// The line text itself has no readout port here, so only the index is kept.
module console_line_editor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_tx_valid,
    input  logic        i_tx_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic        o_line_complete,
    output logic [5:0]  o_line_length,
    output logic [15:0] o_message_count
);

    // decoded entry between editor and echo sequencer
    logic            ent_valid;
    logic            ent_ready;
    cle_pkg::t_entry ent;

    cle_editor u_editor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_ent_valid (ent_valid),
        .i_ent_ready (ent_ready),
        .o_ent       (ent)
    );

    cle_echo u_echo (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ent_valid     (ent_valid),
        .o_ent_ready     (ent_ready),
        .i_ent           (ent),
        .o_tx_valid      (o_tx_valid),
        .i_tx_ready      (i_tx_ready),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last),
        .o_line_complete (o_line_complete),
        .o_line_length   (o_line_length),
        .o_message_count (o_message_count)
    );

endmodule

// ===== hw/rtl/cle_checker.sv =====
// Port-level checks for the console line editor, bound to the top level.
`include "console_line_editor_macros.svh"

module cle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_tx_valid,
    input logic        i_tx_ready,
    input logic [7:0]  o_tx_byte,
    input logic        o_last,
    input logic        o_line_complete,
    input logic [5:0]  o_line_length
);

    `CLE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_tx_valid, "tx valid right after reset")

    `CLE_ASSERT(a_tx_hold, o_tx_valid && !i_tx_ready |=> o_tx_valid && $stable(o_tx_byte), "tx dropped under stall")

    `CLE_ASSERT(a_cr_then_lf, o_tx_valid && i_tx_ready && !o_last && o_tx_byte == cle_pkg::CH_CR |=> o_tx_valid && o_tx_byte == cle_pkg::CH_LF, "CR not followed by LF")

    `CLE_ASSERT(a_done_empty, o_tx_valid && o_line_complete |-> o_line_length == 6'd0, "completed line left a nonzero index")

    `CLE_ASSERT(a_done_crlf, o_tx_valid && o_line_complete |-> o_tx_byte == cle_pkg::CH_CR || o_tx_byte == cle_pkg::CH_LF, "line complete on a non CR/LF byte")

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the console line editor: echo bytes, line length and line count.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous cap. About 280 bytes, at most three echo bytes each, with every
    // echo byte held up by receiver stalls plus sender gaps, stay well under it.
    localparam int CYCLE_LIMIT = 200_000;
    localparam int ITEM_TARGET = 280;

    // One echo byte as the tx side should present it.
    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        last;
        logic        complete;
        logic [5:0]  length;
        logic [15:0] count;
    } t_echo;

    // Clock and reset. Every input has a known value from time zero.
    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        tx_ready = 1'b1;

    logic        o_rx_ready;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    logic        o_line_complete;
    logic [5:0]  o_line_length;
    logic [15:0] o_message_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    console_line_editor i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_rx_valid      (rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (rx_byte),
        .o_tx_valid      (o_tx_valid),
        .i_tx_ready      (tx_ready),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last),
        .o_line_complete (o_line_complete),
        .o_line_length   (o_line_length),
        .o_message_count (o_message_count)
    );

    // Shadow of the editor state. The line text never comes back out, so only
    // the write index and the completed-line count are tracked.
    int          line_len = 0;
    logic [15:0] lines_total = 16'd0;
    t_echo       echo_q[$];

    // Bookkeeping for the summary.
    int          errors = 0;
    int          items_sent = 0;
    int          active_items = 0;
    int          echoes_checked = 0;
    int          op_count[3] = '{0, 0, 0};
    int          max_len = 0;

    int          burst_left = 0;

    // Works out the echo bytes one received byte causes and queues them.
    // Returns how many there are; zero means the editor ignores the byte.
    function automatic int predict_echo(input logic [7:0] b);
        logic [7:0]     seq[3];
        int             n;
        logic           done;
        cle_pkg::t_op   kind;
        t_echo          e;
        n = 0;
        done = 1'b0;
        kind = cle_pkg::OP_CHR;
        if (b == cle_pkg::CH_CR) begin
            // Line end: counted only when something was typed.
            kind = cle_pkg::OP_CR;
            if (line_len != 0) begin
                done = 1'b1;
                lines_total = lines_total + 16'd1;
            end
            line_len = 0;
            seq[0] = cle_pkg::CH_CR;
            seq[1] = cle_pkg::CH_LF;
            n = 2;
        end else if (b == cle_pkg::CH_DEL) begin
            // Backspace erases on screen with DEL, space, DEL.
            kind = cle_pkg::OP_DEL;
            if (line_len != 0) begin
                line_len = line_len - 1;
                seq[0] = cle_pkg::CH_DEL;
                seq[1] = cle_pkg::CH_SPACE;
                seq[2] = cle_pkg::CH_DEL;
                n = 3;
            end
        end else if (b >= cle_pkg::CH_SPACE && b <= cle_pkg::CH_TILDE
                     && line_len < cle_pkg::LINE_SIZE - 1) begin
            // Printable, with room left ahead of the terminator slot.
            line_len = line_len + 1;
            seq[0] = b;
            n = 1;
        end
        for (int k = 0; k < n; k++) begin
            e.tx_byte  = seq[k];
            e.last     = (k == n - 1);
            e.complete = done;
            e.length   = line_len[5:0];
            e.count    = lines_total;
            echo_q.push_back(e);
        end
        if (n > 0)
            op_count[kind] = op_count[kind] + 1;
        if (line_len > max_len)
            max_len = line_len;
        return n;
    endfunction

    // Offers one byte on rx and returns at the edge where it transfers. Valid is
    // left high so a following byte goes out without a bubble; a gap, when one
    // is due, lowers it at a later edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge i_clk);
        while (!(rx_valid && o_rx_ready));
        items_sent = items_sent + 1;
        if (predict_echo(b) > 0)
            active_items = active_items + 1;
    endtask

    // Receiver: tx_ready walks a 32-bit pattern, redrawn as stall_phase wraps. A
    // quarter of the patterns are solid ready, the rest stall about a quarter of the time.
    logic [31:0] stall_pat = '1;
    logic [4:0]  stall_phase = 5'd0;

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 5'd1;
        if (stall_phase == 5'd31)
            stall_pat <= ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
        tx_ready <= stall_pat[stall_phase];
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors = errors + 1;
        end
    endfunction

    // Every tx transfer is matched against the oldest queued echo byte.
    t_echo head;

    always @(posedge i_clk) begin
        if (rst_n && o_tx_valid && tx_ready) begin
            if (echo_q.size() == 0) begin
                $error("tx transfer with nothing expected: byte %0h", o_tx_byte);
                errors = errors + 1;
            end else begin
                head = echo_q.pop_front();
                check_field("tx_byte", 16'(head.tx_byte), 16'(o_tx_byte));
                check_field("last", 16'(head.last), 16'(o_last));
                check_field("line_complete", 16'(head.complete), 16'(o_line_complete));
                check_field("line_length", 16'(head.length), 16'(o_line_length));
                check_field("message_count", head.count, o_message_count);
                echoes_checked = echoes_checked + 1;
            end
        end
    end

    // Watchdog.
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Bytes with no echo: line feed, other controls, high codes, backspace on an
    // empty line, and a carriage return on an empty line (echo but no count).
    task automatic test_ignored_bytes();
        send_byte(cle_pkg::CH_LF);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(cle_pkg::CH_DEL);
        send_byte(cle_pkg::CH_CR);
    endtask

    // Printable extremes, a backspace, and a line that gets counted.
    task automatic test_basic_edit();
        send_byte(cle_pkg::CH_SPACE);
        send_byte(cle_pkg::CH_TILDE);
        send_byte("A");
        send_byte(cle_pkg::CH_DEL);
        send_byte("b");
        send_byte(cle_pkg::CH_CR);
    endtask

    // Fill up to the terminator slot, then check that printables are dropped,
    // that backspace frees a slot, and that CR ends a full line.
    task automatic test_full_line();
        repeat (cle_pkg::LINE_SIZE - 1) send_byte(8'($urandom_range(32, 126)));
        send_byte(cle_pkg::CH_TILDE);
        send_byte(cle_pkg::CH_SPACE);
        send_byte(cle_pkg::CH_DEL);
        send_byte("Z");
        send_byte("q");
        send_byte(cle_pkg::CH_CR);
    endtask

    // Mostly typed lines with random text and backspaces, mixed with noise,
    // stray line feeds, runs of backspace and lines left open.
    task automatic test_random_lines();
        int len;
        while (items_sent < ITEM_TARGET) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70)
                                              : $urandom_range(0, 15);
            for (int k = 0; k < len && items_sent < ITEM_TARGET; k++) begin
                case ($urandom_range(0, 19))
                    0: send_byte(cle_pkg::CH_DEL);
                    1: send_byte(8'($urandom_range(0, 255)));
                    2: send_byte(cle_pkg::CH_LF);
                    3: repeat ($urandom_range(1, 4)) send_byte(cle_pkg::CH_DEL);
                    default: send_byte(8'($urandom_range(32, 126)));
                endcase
            end
            if ($urandom_range(0, 7) != 0)
                send_byte(cle_pkg::CH_CR);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_ignored_bytes();
        test_basic_edit();
        test_full_line();
        test_random_lines();

        // Drain, then keep the clock running so any stray transfer shows.
        rx_valid <= 1'b0;
        while (echo_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes (%0d echoed: %0d printable, %0d CR, %0d DEL).",
                 items_sent, active_items, op_count[cle_pkg::OP_CHR],
                 op_count[cle_pkg::OP_CR], op_count[cle_pkg::OP_DEL]);
        $display("%0d echo bytes checked, longest line %0d, final line count %0d.",
                 echoes_checked, max_len, lines_total);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cle_pkg.sv
hw/rtl/cle_editor.sv
hw/rtl/cle_echo.sv
hw/rtl/console_line_editor.sv
hw/rtl/cle_checker.sv
verif/testbench.sv
